### design/omni_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode program for the omni wheel move unit.
package omni_pkg;

  localparam int END_BITS = 34;
  localparam int PC_BITS  = 4;
  localparam int OP_BITS  = 4;
  localparam int CND_BITS = 3;
  localparam int Q_BITS   = 16;

  // 2 * sin 60 deg in Q1.15
  localparam logic [16:0] SIN60_X2 = 17'd56756;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  localparam logic [1:0] WHEEL_LAST = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic REG_DRIVE_SPEED = 1'b0;
  localparam logic REG_ROT_COEFF   = 1'b1;

  // datapath operations
  localparam logic [OP_BITS-1:0] OP_NOP   = 4'd0;
  localparam logic [OP_BITS-1:0] OP_MUL   = 4'd1;
  localparam logic [OP_BITS-1:0] OP_SUM   = 4'd2;
  localparam logic [OP_BITS-1:0] OP_ROUND = 4'd3;
  localparam logic [OP_BITS-1:0] OP_MAG   = 4'd4;
  localparam logic [OP_BITS-1:0] OP_BIG   = 4'd5;
  localparam logic [OP_BITS-1:0] OP_MULN  = 4'd6;
  localparam logic [OP_BITS-1:0] OP_DINIT = 4'd7;
  localparam logic [OP_BITS-1:0] OP_DSTEP = 4'd8;
  localparam logic [OP_BITS-1:0] OP_STORE = 4'd9;
  localparam logic [OP_BITS-1:0] OP_FIN   = 4'd10;
  localparam logic [OP_BITS-1:0] OP_TICK  = 4'd11;

  // sequencing conditions
  localparam logic [CND_BITS-1:0] C_NEXT   = 3'd0;
  localparam logic [CND_BITS-1:0] C_ALWAYS = 3'd1;
  localparam logic [CND_BITS-1:0] C_DIV    = 3'd2;
  localparam logic [CND_BITS-1:0] C_WHEEL  = 3'd3;
  localparam logic [CND_BITS-1:0] C_FIN    = 3'd4;

  // program addresses
  localparam logic [PC_BITS-1:0] PC_START = 4'd0;
  localparam logic [PC_BITS-1:0] PC_MULN  = 4'd5;
  localparam logic [PC_BITS-1:0] PC_DSTEP = 4'd7;
  localparam logic [PC_BITS-1:0] PC_FIN   = 4'd9;
  localparam logic [PC_BITS-1:0] PC_TICK  = 4'd10;

  typedef struct packed {
    logic [OP_BITS-1:0]  op;
    logic [CND_BITS-1:0] cond;
    logic [PC_BITS-1:0]  target;
  } omni_uword_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [1:0]         wheel;
    logic [3:0]         bit_idx;
  } omni_ctrl_t;

  function automatic omni_uword_t omni_rom(input logic [PC_BITS-1:0] pc);
    omni_uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_MUL,   cond: C_NEXT,   target: PC_START};
      4'd1:    w = '{op: OP_SUM,   cond: C_NEXT,   target: PC_START};
      4'd2:    w = '{op: OP_ROUND, cond: C_NEXT,   target: PC_START};
      4'd3:    w = '{op: OP_MAG,   cond: C_NEXT,   target: PC_START};
      4'd4:    w = '{op: OP_BIG,   cond: C_NEXT,   target: PC_START};
      4'd5:    w = '{op: OP_MULN,  cond: C_NEXT,   target: PC_START};
      4'd6:    w = '{op: OP_DINIT, cond: C_NEXT,   target: PC_START};
      4'd7:    w = '{op: OP_DSTEP, cond: C_DIV,    target: PC_DSTEP};
      4'd8:    w = '{op: OP_STORE, cond: C_WHEEL,  target: PC_MULN};
      4'd9:    w = '{op: OP_FIN,   cond: C_FIN,    target: PC_FIN};
      4'd10:   w = '{op: OP_TICK,  cond: C_ALWAYS, target: PC_FIN};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS, target: PC_FIN};
    endcase
    return w;
  endfunction

endpackage

### design/omni_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program ROM, wheel and divide-bit counters.
module omni_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                start_tick,
  input  logic                out_busy,
  output logic                busy,
  output omni_pkg::omni_ctrl_t ctrl
);
  import omni_pkg::*;

  logic [PC_BITS-1:0] pc;
  logic [1:0]         wheel;
  logic [3:0]         cnt;
  omni_uword_t        uw;

  assign uw = omni_rom(pc);

  always_comb begin
    ctrl.op      = busy ? uw.op : OP_NOP;
    ctrl.wheel   = wheel;
    ctrl.bit_idx = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pc    <= PC_START;
      wheel <= '0;
      cnt   <= '0;
    end else if (!busy) begin
      if (start) begin
        busy  <= 1'b1;
        pc    <= start_tick ? PC_TICK : PC_START;
        wheel <= '0;
      end
    end else begin
      case (uw.op)
        OP_DINIT: cnt   <= '1;
        OP_DSTEP: cnt   <= cnt - 4'd1;
        OP_STORE: wheel <= wheel + 2'd1;
        default: ;
      endcase
      case (uw.cond)
        C_NEXT:   pc <= pc + 4'd1;
        C_ALWAYS: pc <= uw.target;
        C_DIV:    pc <= (cnt != '0) ? uw.target : pc + 4'd1;
        C_WHEEL:  pc <= (wheel != WHEEL_LAST) ? uw.target : pc + 4'd1;
        C_FIN: begin
          if (!out_busy) busy <= 1'b0;
        end
        default:  busy <= 1'b0;
      endcase
    end
  end

endmodule

### design/omni_wheel_move_to_position_unit.sv
`timescale 1ns / 1ps
// Omni wheel move-to-position unit: datapath, state and handshake.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, req_type, target_*, enc_*  | into block
//  out     | out_valid, out_stall, speed_*, moving, done_res | out of block
//  cfg     | cfg_we, cfg_index, cfg_data                    | into block
//
// Start item: 5 setup steps, then per wheel a multiply, a load, 16 steps of
// the bit-serial divider and a store, then finish. Tick item: a tick step,
// then finish. One item in flight; the next is taken once the result
// sits in the output register. A stalled output holds the finish step.
// Reset is synchronous: clears control and moves, restores config defaults.
module omni_wheel_move_to_position_unit #(
  parameter int TARGET_BITS  = 24,
  parameter int ENCODER_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic signed [TARGET_BITS-1:0]  target_x,
  input  logic signed [TARGET_BITS-1:0]  target_y,
  input  logic signed [TARGET_BITS-1:0]  target_rot,
  input  logic signed [ENCODER_BITS-1:0] enc_left,
  input  logic signed [ENCODER_BITS-1:0] enc_right,
  input  logic signed [ENCODER_BITS-1:0] enc_back,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             speed_left,
  output logic signed [15:0]             speed_right,
  output logic signed [15:0]             speed_back,
  output logic                           moving,
  output logic                           done_res,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [15:0]                    cfg_data
);
  import omni_pkg::*;

  localparam int PXW = TARGET_BITS + 18;
  localparam int PRW = TARGET_BITS + 17;
  localparam int SW  = TARGET_BITS + 26;
  localparam int DW  = SW - 16;
  localparam int MW  = DW;
  localparam int NW  = MW + 17;
  localparam int EX  = (DW > ENCODER_BITS) ? DW : ENCODER_BITS;
  localparam int ESW = ((EX > END_BITS) ? EX : END_BITS) + 1;
  localparam logic signed [ESW-1:0] END_HI =
    {{(ESW-END_BITS+1){1'b0}}, {(END_BITS-1){1'b1}}};
  localparam logic signed [ESW-1:0] END_LO =
    {{(ESW-END_BITS+1){1'b1}}, {(END_BITS-1){1'b0}}};

  logic [14:0] drive_speed;
  logic [15:0] rot_coeff;

  logic signed [TARGET_BITS-1:0]  x_r, y_r, w_r;
  logic signed [ENCODER_BITS-1:0] enc_r [3];
  logic signed [PXW-1:0]          sx_r;
  logic signed [PRW-1:0]          rw_r;
  logic signed [SW-1:0]           sum_r [3];
  logic signed [DW-1:0]           dist_r [3];
  logic [MW-1:0]                  mag_r [3];
  logic [MW-1:0]                  big_r;
  logic [NW-1:0]                  num_r;
  logic [MW:0]                    rem_r;
  logic [Q_BITS-1:0]              q_r;

  logic signed [END_BITS-1:0] wheel_end [3];
  logic [1:0]                 wheel_dir [3];
  logic signed [15:0]         wheel_speed [3];
  logic                       active;
  logic                       done_r;

  logic       accept, busy, out_busy;
  omni_ctrl_t ctrl;

  logic signed [PXW-1:0]      sx_next;
  logic signed [PRW-1:0]      rw_next;
  logic signed [SW-1:0]       sum_next [3];
  logic signed [DW-1:0]       dist_next [3];
  logic [MW-1:0]              mag_next [3];
  logic signed [END_BITS-1:0] end_next [3];
  logic [1:0]                 dir_next [3];
  logic [MW-1:0]              big_next;
  logic [NW-1:0]              num_next;
  logic [MW+1:0]              trial;
  logic [MW+1:0]              dvs;
  logic [15:0]                num_low;
  logic signed [15:0]         speed_next;
  logic                       passed;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;
  assign out_busy = out_valid && out_stall;

  omni_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .start_tick (req_type == REQ_TICK),
    .out_busy   (out_busy),
    .busy       (busy),
    .ctrl       (ctrl)
  );

  always_comb begin
    logic signed [SW-1:0]       t_sx, t_hy, t_y, t_rw, rs;
    logic signed [ESW-1:0]      es;
    logic signed [END_BITS-1:0] e;
    logic [Q_BITS-1:0]          sp;
    sx_next = x_r * $signed({1'b0, SIN60_X2});
    rw_next = w_r * $signed({1'b0, rot_coeff});
    t_sx = SW'(sx_r);
    t_hy = SW'(y_r) <<< 15;
    t_y  = SW'(y_r) <<< 16;
    t_rw = SW'(rw_r) <<< 8;
    sum_next[0] = t_sx - t_hy + t_rw;
    sum_next[1] = -t_sx - t_hy + t_rw;
    sum_next[2] = t_y + t_rw;
    passed = 1'b0;
    for (int k = 0; k < 3; k++) begin
      // round half away from zero
      rs = sum_r[k] + (sum_r[k][SW-1] ? SW'(32767) : SW'(32768));
      dist_next[k] = $signed(rs[SW-1:16]);
      mag_next[k]  = dist_r[k][DW-1] ? MW'(-dist_r[k]) : MW'(dist_r[k]);
      es = ESW'(enc_r[k]) + ESW'(dist_r[k]);
      if (es > END_HI) es = END_HI;
      if (es < END_LO) es = END_LO;
      end_next[k] = es[END_BITS-1:0];
      if (dist_r[k][DW-1])       dir_next[k] = DIR_BWD;
      else if (dist_r[k] != '0)  dir_next[k] = DIR_FWD;
      else                       dir_next[k] = DIR_NONE;
      e = END_BITS'(enc_r[k]);
      if ((wheel_dir[k] == DIR_FWD && e > wheel_end[k]) ||
          (wheel_dir[k] == DIR_BWD && e < wheel_end[k])) passed = 1'b1;
    end
    big_next = mag_r[0];
    if (mag_r[1] > big_next) big_next = mag_r[1];
    if (mag_r[2] > big_next) big_next = mag_r[2];
    num_next = NW'({drive_speed, 1'b0}) * NW'(mag_r[ctrl.wheel]) + NW'(big_r);
    num_low  = num_r[15:0];
    trial    = {rem_r, num_low[ctrl.bit_idx]};
    dvs      = {1'b0, big_r, 1'b0};
    sp       = (big_r == '0) ? '0 : q_r;
    speed_next = dist_r[ctrl.wheel][DW-1] ? -$signed(sp) : $signed(sp);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_speed <= 15'd16384;
      rot_coeff   <= 16'd256;
    end else if (cfg_we) begin
      if (cfg_index == REG_DRIVE_SPEED) drive_speed <= cfg_data[14:0];
      else                              rot_coeff   <= cfg_data;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= target_x;
      y_r      <= target_y;
      w_r      <= target_rot;
      enc_r[0] <= enc_left;
      enc_r[1] <= enc_right;
      enc_r[2] <= enc_back;
    end
    case (ctrl.op)
      OP_MUL: begin
        sx_r <= sx_next;
        rw_r <= rw_next;
      end
      OP_SUM:   sum_r  <= sum_next;
      OP_ROUND: dist_r <= dist_next;
      OP_MAG:   mag_r  <= mag_next;
      OP_BIG:   big_r  <= big_next;
      OP_MULN:  num_r  <= num_next;
      OP_DINIT: begin
        rem_r <= num_r[NW-1:16];
        q_r   <= '0;
      end
      OP_DSTEP: begin
        if (trial >= dvs) begin
          rem_r <= (MW+1)'(trial - dvs);
          q_r   <= {q_r[Q_BITS-2:0], 1'b1};
        end else begin
          rem_r <= trial[MW:0];
          q_r   <= {q_r[Q_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        wheel_end[k]   <= '0;
        wheel_dir[k]   <= DIR_NONE;
        wheel_speed[k] <= '0;
      end
      active <= 1'b0;
      done_r <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_MUL: done_r <= 1'b0;
        OP_MAG: begin
          wheel_end <= end_next;
          wheel_dir <= dir_next;
          active    <= 1'b1;
        end
        OP_STORE: wheel_speed[ctrl.wheel] <= speed_next;
        OP_TICK: begin
          done_r <= active && passed;
          if (active && passed) begin
            for (int k = 0; k < 3; k++) wheel_speed[k] <= '0;
            active <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_FIN && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FIN && !out_busy) begin
      speed_left  <= wheel_speed[0];
      speed_right <= wheel_speed[1];
      speed_back  <= wheel_speed[2];
      moving      <= active;
      done_res    <= done_r;
    end
  end

endmodule
